/* hw/rtl/isl_pkg.sv */
// Shared types, codes and default sizes for the indexed shift list.
package isl_pkg;

    // Default sizes
    localparam int CAPACITY_DEF      = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // Fixed field widths of the item ports
    localparam int REQ_W     = 3;
    localparam int IDX_W     = 5;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INS_IDX = 3'd0,
        REQ_PUSH    = 3'd1,
        REQ_REMOVE  = 3'd2,
        REQ_POP     = 3'd3,
        REQ_READ    = 3'd4,
        REQ_SORT    = 3'd5,
        REQ_CLEAR   = 3'd6
    } t_req;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // What every cell of the row does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD     = 2'd0,
        CELL_INS_IDX  = 2'd1,
        CELL_INS_SORT = 2'd2,
        CELL_REMOVE   = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       descending;
    } t_cell_ctl;

    // Input item
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_req_item;

    // Result item
    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [VAL_W-1:0]     read_value;
        logic [CNT_OUT_W-1:0] element_count;
    } t_res_item;

endpackage

/* hw/rtl/isl_cell.sv */
// One storage cell of the list: holds one element, shifts with its neighbors.
module isl_cell
    import isl_pkg::*;
#(
    parameter int K     = 0,
    parameter int CNT_W = 5,
    parameter int EW    = ELEMENT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_pos,
    input  logic [CNT_W-1:0] i_count,
    input  logic [EW-1:0]    i_val,
    input  logic [EW-1:0]    i_left,
    input  logic [EW-1:0]    i_right,
    input  logic             i_prefix,
    output logic             o_prefix,
    output logic [EW-1:0]    o_data
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(K);

    logic [EW-1:0] r_data;
    logic [EW-1:0] n_data;
    logic          w_live;
    logic          w_go;

    // New value still belongs after this cell's element
    assign w_live   = MY_POS < i_count;
    assign w_go     = w_live && (i_ctl.descending ? (i_val < r_data) : (i_val > r_data));
    assign o_prefix = i_prefix && w_go;
    assign o_data   = r_data;

    // Pick hold, shift up, shift down or load
    always_comb begin
        n_data = r_data;
        case (i_ctl.mode)
            CELL_INS_IDX: begin
                if (MY_POS > i_pos) begin
                    n_data = i_left;
                end else if (MY_POS == i_pos) begin
                    n_data = i_val;
                end
            end
            CELL_INS_SORT: begin
                if (!i_prefix) begin
                    n_data = i_left;
                end else if (!w_go) begin
                    n_data = i_val;
                end
            end
            CELL_REMOVE: begin
                if (MY_POS >= i_pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* hw/rtl/indexed_shift_list.sv */
// Top level of the indexed shift list: request decode, cell row and result register.
//
//   channel   direction  handshake                 payload
//   request   in         start high, busy low      i_req (t_req_item)
//   result    out        o_done strobe, one cycle  o_res (t_res_item)
//   config    in         i_cfg_valid/o_cfg_ready   i_cfg_data (descending order)
//
// Every request is handled by the whole cell row together: all cells compare and shift
// together, so busy stays low and a new request may start every cycle.
// The result is registered: o_res shows it from the cycle after its request until the next request.
// Reset empties the list and selects ascending order; cell contents are not cleared.
// The receiver cannot stall, so nothing holds results back.
module indexed_shift_list
    import isl_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_req_item i_req,
    output logic      o_done,
    output t_res_item o_res,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam int EW    = ELEMENT_WIDTH;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int XW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic             r_desc;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_res_item        r_res;
    t_res_item        n_res;

    logic             w_accept;
    logic [XW-1:0]    w_idx_x;
    logic [XW-1:0]    w_cnt_x;
    logic             w_full;
    logic             w_empty;
    logic [EW-1:0]    w_val;
    logic [EW-1:0]    w_rd;
    logic [VAL_W-1:0] w_rd_out;
    logic             w_rd_en;
    t_status          w_status;
    t_cell_mode       w_mode;
    t_cell_ctl        w_ctl;
    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_cnt_next;

    logic [EW-1:0]    w_data   [CAPACITY];
    logic [EW-1:0]    w_left   [CAPACITY];
    logic [EW-1:0]    w_right  [CAPACITY];
    logic             w_prefix [CAPACITY+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    assign w_idx_x = XW'(i_req.index);
    assign w_cnt_x = XW'(r_count);
    assign w_full  = r_count == CAP_C;
    assign w_empty = r_count == '0;

    // Fit the incoming value to the element width
    generate
        if (EW > VAL_W) begin : g_val_wide
            assign w_val = {{(EW - VAL_W){1'b0}}, i_req.value};
        end else begin : g_val_narrow
            assign w_val = i_req.value[EW-1:0];
        end
    endgenerate

    // Decode the request into a row command, status and new count
    always_comb begin
        w_status   = ST_OK;
        w_mode     = CELL_HOLD;
        w_pos      = CNT_W'(w_idx_x);
        w_cnt_next = r_count;
        w_rd_en    = 1'b0;
        case (t_req'(i_req.req_type))
            REQ_INS_IDX: begin
                if (w_idx_x > w_cnt_x) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_mode     = CELL_INS_IDX;
                    w_cnt_next = r_count + 1'b1;
                end
            end
            REQ_PUSH: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_mode     = CELL_INS_IDX;
                    w_pos      = r_count;
                    w_cnt_next = r_count + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_idx_x >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_mode     = CELL_REMOVE;
                    w_rd_en    = 1'b1;
                    w_cnt_next = r_count - 1'b1;
                end
            end
            REQ_POP: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_mode     = CELL_REMOVE;
                    w_pos      = r_count - 1'b1;
                    w_rd_en    = 1'b1;
                    w_cnt_next = r_count - 1'b1;
                end
            end
            REQ_READ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_idx_x >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            REQ_SORT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_mode     = CELL_INS_SORT;
                    w_cnt_next = r_count + 1'b1;
                end
            end
            REQ_CLEAR: begin
                w_cnt_next = '0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Drive the row only for an accepted item
    assign w_ctl.mode       = w_accept ? w_mode : CELL_HOLD;
    assign w_ctl.descending = r_desc;

    // Row of cells; the sort prefix ripples from the front
    assign w_prefix[0] = 1'b1;

    generate
        for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
            if (k == 0) begin : g_first
                assign w_left[k] = w_val;
            end else begin : g_mid
                assign w_left[k] = w_data[k-1];
            end
            if (k == CAPACITY - 1) begin : g_last
                assign w_right[k] = w_data[k];
            end else begin : g_inner
                assign w_right[k] = w_data[k+1];
            end

            isl_cell #(
                .K     (k),
                .CNT_W (CNT_W),
                .EW    (EW)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl),
                .i_pos    (w_pos),
                .i_count  (r_count),
                .i_val    (w_val),
                .i_left   (w_left[k]),
                .i_right  (w_right[k]),
                .i_prefix (w_prefix[k]),
                .o_prefix (w_prefix[k+1]),
                .o_data   (w_data[k])
            );
        end
    endgenerate

    // Select the element read or removed
    assign w_rd = w_rd_en ? w_data[IW'(w_pos)] : '0;

    generate
        if (EW < VAL_W) begin : g_rd_narrow
            assign w_rd_out = {{(VAL_W - EW){1'b0}}, w_rd};
        end else begin : g_rd_wide
            assign w_rd_out = w_rd[VAL_W-1:0];
        end
    endgenerate

    // Assemble the result
    always_comb begin
        n_res.status        = w_status;
        n_res.read_value    = w_rd_out;
        n_res.element_count = CNT_OUT_W'(w_cnt_next);
    end

    assign n_count = w_accept ? w_cnt_next : r_count;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_desc  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_desc <= i_cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
